FILE: design/asp_pkg.sv
`default_nettype none

package asp_pkg;

	// Field widths
	localparam int ANGLE_W    = 16;
	localparam int ELAPSED_W  = 16;
	localparam int PRESSURE_W = 16;
	localparam int SPEED_W    = 26;
	localparam int SCALE_W    = 20;
	localparam int WEIGHT_W   = 9;
	localparam int PRODUCT_W  = WEIGHT_W + PRESSURE_W;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd4;

	// Register reset values
	localparam logic [SCALE_W-1:0]  FULL_SCALE_RST = 20'd5000;
	localparam logic [SCALE_W-1:0]  DEADBAND_RST   = 20'd100;
	localparam logic [WEIGHT_W-1:0] ATTACK_RST     = 9'd166;
	localparam logic [WEIGHT_W-1:0] RELEASE_RST    = 9'd230;

	// Arithmetic constants
	localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE   = 9'd256;
	localparam logic [SPEED_W-1:0]    MS_PER_S     = 26'd1000;
	localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = 16'hFFFF;

	// Serial divider step counts: speed quotient, then Q0.16 target quotient
	localparam int DIV1_STEPS = SPEED_W;
	localparam int DIV2_STEPS = PRESSURE_W;
	localparam int STEP_W     = $clog2(DIV1_STEPS);

	typedef struct packed {
		logic [ANGLE_W-1:0]   angle;
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 restart;
	} sample_t;

	typedef struct packed {
		logic [PRESSURE_W-1:0] pressure;
		logic [SPEED_W-1:0]    speed;
		logic                  updated;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // capture sample
		logic restart;     // record angle, zero pressure and speed
		logic record;      // record angle only
		logic start_div1;  // load |delta|*1000 / elapsed
		logic div_step;    // one restoring division step
		logic scale;       // deadband, store speed, record angle, load speed<<16 / full scale
		logic mix1;        // pick weight, weight * target
		logic mix2;        // blend with pressure
		logic out_load;    // load result register
		logic out_updated;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic enabled;
		logic first;
		logic zero_elapsed;
	} sts_t;

endpackage

`default_nettype wire

FILE: design/angle_speed_pressure_follower_core.sv
// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  sample_t {angle, elapsed_ms, restart}
// result    out        result_valid/result_ready  result_t {pressure, speed, updated}
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A normal sample runs through one shared restoring divider, one bit per cycle,
// 26 steps for the speed and 16 for the target, plus the decode, scale, blend
// (mix1, mix2) and finish steps. Disabled, restart and zero-time samples go from
// decode straight to finish. A new sample is taken only in idle, after the last
// one leaves finish. A waiting result does not block the next sample; a second
// result waits in the finish step until the register frees. Reset is asynchronous
// and restores the register defaults; cfg_ready is always high.
`default_nettype none

module angle_speed_pressure_follower_core import asp_pkg::*; (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  sample_valid,
	output logic                        sample_ready,
	input  wire  sample_t               sample,
	output logic                        result_valid,
	input  wire  logic                  result_ready,
	output result_t                     result,
	input  wire  logic                  cfg_valid,
	output logic                        cfg_ready,
	input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	asp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	asp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: design/asp_ctrl.sv
`default_nettype none

module asp_ctrl import asp_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic sample_valid,
	output logic       sample_ready,
	output logic       result_valid,
	input  wire  logic result_ready,
	input  wire  sts_t sts,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DIV1   = 3'd2;
	localparam logic [2:0] ST_SCALE  = 3'd3;
	localparam logic [2:0] ST_DIV2   = 3'd4;
	localparam logic [2:0] ST_MIX1   = 3'd5;
	localparam logic [2:0] ST_MIX2   = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	localparam logic [STEP_W-1:0] DIV1_LAST = STEP_W'(DIV1_STEPS - 1);
	localparam logic [STEP_W-1:0] DIV2_LAST = STEP_W'(DIV2_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              upd_q, upd_d;
	logic              valid_q;
	logic              out_free;

	assign out_free     = !valid_q || result_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = valid_q;

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cnt_d           = cnt_q;
		upd_d           = upd_q;
		cmd             = '0;
		cmd.out_updated = upd_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = sample_valid;
				if (sample_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!sts.enabled) begin
					upd_d   = 1'b0;
					state_d = ST_FINISH;
				end else if (sts.first) begin
					cmd.restart = 1'b1;
					upd_d       = 1'b1;
					state_d     = ST_FINISH;
				end else if (sts.zero_elapsed) begin
					cmd.record = 1'b1;
					upd_d      = 1'b0;
					state_d    = ST_FINISH;
				end else begin
					cmd.start_div1 = 1'b1;
					cnt_d          = DIV1_LAST;
					state_d        = ST_DIV1;
				end
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				cnt_d     = DIV2_LAST;
				upd_d     = 1'b1;
				state_d   = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_MIX1;
				end
			end
			ST_MIX1: begin
				cmd.mix1 = 1'b1;
				state_d  = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.mix2 = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			upd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			upd_q   <= upd_d;
		end
	end

	// Result valid: set on load, cleared when the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/asp_dp.sv
`default_nettype none

module asp_dp import asp_pkg::*; (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  sample_t               sample,
	input  wire  logic                  cfg_we,
	input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [CFG_DATA_W-1:0] cfg_data,
	input  wire  cmd_t                  cmd,
	output sts_t                        sts,
	output result_t                     result
);

	// Configuration
	logic                enabled_q;
	logic [SCALE_W-1:0]  full_scale_q;
	logic [SCALE_W-1:0]  deadband_q;
	logic [WEIGHT_W-1:0] attack_q;
	logic [WEIGHT_W-1:0] release_q;

	// Follower state
	sample_t               sample_q;
	logic [ANGLE_W-1:0]    prev_angle_q;
	logic                  have_prev_q;
	logic [PRESSURE_W-1:0] pressure_q;
	logic [SPEED_W-1:0]    speed_q;

	// Shared divider
	logic [SCALE_W-1:0] rem_q;
	logic [SPEED_W-1:0] num_q;
	logic [SPEED_W-1:0] quot_q;
	logic [SCALE_W-1:0] divisor_q;
	logic               sat_q;

	// Blend
	logic [PRODUCT_W-1:0] prod_q;
	logic [WEIGHT_W-1:0]  wc_q;
	result_t              result_q;

	logic [ANGLE_W-1:0]    delta;
	logic [SPEED_W-1:0]    scaled_delta;
	logic [SCALE_W:0]      trial;
	logic                  trial_ge;
	logic [SCALE_W-1:0]    rem_next;
	logic [SPEED_W-1:0]    speed_db;
	logic [SCALE_W-1:0]    fs_eff;
	logic [PRESSURE_W-1:0] target;
	logic [WEIGHT_W-1:0]   w_raw;
	logic [WEIGHT_W-1:0]   w_sat;
	logic [SPEED_W-1:0]    blend_sum;

	assign sts.enabled      = enabled_q;
	assign sts.first        = sample_q.restart || !have_prev_q;
	assign sts.zero_elapsed = (sample_q.elapsed_ms == '0);
	assign result           = result_q;

	// Angle difference scaled to per-second
	assign delta = (sample_q.angle >= prev_angle_q) ? (sample_q.angle - prev_angle_q)
	                                                : (prev_angle_q - sample_q.angle);
	assign scaled_delta = SPEED_W'(delta) * MS_PER_S;

	// Restoring division step
	assign trial    = {rem_q, num_q[SPEED_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign rem_next = trial_ge ? SCALE_W'(trial - {1'b0, divisor_q}) : trial[SCALE_W-1:0];

	// Deadband and full-scale guard
	assign speed_db = (quot_q < SPEED_W'(deadband_q)) ? '0 : quot_q;
	assign fs_eff   = (full_scale_q == '0) ? SCALE_W'(1) : full_scale_q;

	// Target and weight selection
	assign target = sat_q ? PRESSURE_MAX : quot_q[PRESSURE_W-1:0];
	assign w_raw  = (target >= pressure_q) ? attack_q : release_q;
	assign w_sat  = (w_raw > WEIGHT_ONE) ? WEIGHT_ONE : w_raw;

	// Rounded blend; the second product lands here after the first was registered
	assign blend_sum = SPEED_W'(prod_q) + SPEED_W'(wc_q * pressure_q) + SPEED_W'(128);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			full_scale_q <= FULL_SCALE_RST;
			deadband_q   <= DEADBAND_RST;
			attack_q     <= ATTACK_RST;
			release_q    <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:     enabled_q    <= cfg_data[0];
				CFG_FULL_SCALE: full_scale_q <= cfg_data[SCALE_W-1:0];
				CFG_DEADBAND:   deadband_q   <= cfg_data[SCALE_W-1:0];
				CFG_ATTACK:     attack_q     <= cfg_data[WEIGHT_W-1:0];
				CFG_RELEASE:    release_q    <= cfg_data[WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			have_prev_q  <= 1'b0;
			pressure_q   <= '0;
			speed_q      <= '0;
		end else begin
			if (cmd.restart) begin
				prev_angle_q <= sample_q.angle;
				have_prev_q  <= 1'b1;
				pressure_q   <= '0;
				speed_q      <= '0;
			end
			if (cmd.record) begin
				prev_angle_q <= sample_q.angle;
			end
			if (cmd.scale) begin
				prev_angle_q <= sample_q.angle;
				speed_q      <= speed_db;
			end
			if (cmd.mix2) begin
				pressure_q <= (blend_sum[SPEED_W-1:PRESSURE_W+8] != '0) ? PRESSURE_MAX
				              : blend_sum[PRESSURE_W+7:8];
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.start_div1) begin
			rem_q     <= '0;
			num_q     <= scaled_delta;
			quot_q    <= '0;
			divisor_q <= SCALE_W'(sample_q.elapsed_ms);
		end else if (cmd.scale) begin
			// remainder starts at speed, sixteen zero bits shift in
			rem_q     <= speed_db[SCALE_W-1:0];
			num_q     <= '0;
			quot_q    <= '0;
			divisor_q <= fs_eff;
			sat_q     <= (speed_db >= SPEED_W'(fs_eff));
		end else if (cmd.div_step) begin
			rem_q  <= rem_next;
			num_q  <= {num_q[SPEED_W-2:0], 1'b0};
			quot_q <= {quot_q[SPEED_W-2:0], trial_ge};
		end
		if (cmd.mix1) begin
			prod_q <= w_sat * target;
			wc_q   <= WEIGHT_ONE - w_sat;
		end
		if (cmd.out_load) begin
			result_q.pressure <= pressure_q;
			result_q.speed    <= speed_q;
			result_q.updated  <= cmd.out_updated;
		end
	end

endmodule

`default_nettype wire

FILE: design/asp_checker.sv
`default_nettype none

module asp_checker import asp_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_valid,
	input wire logic    sample_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	logic [1:0] pend_q;
	logic       in_txn;
	logic       out_txn;

	assign in_txn  = sample_valid && sample_ready;
	assign out_txn = result_valid && result_ready;

	// Samples accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_txn} - {1'b0, out_txn};
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_txn |=> !sample_ready)
		else $error("sample taken while previous one still in work");

	a_pending_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transactions in flight");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result offered with no sample pending");

endmodule

bind angle_speed_pressure_follower_core asp_checker u_chk (.*);

`default_nettype wire

FILE: verif/angle_speed_pressure_follower_core_tb.sv
`timescale 1ns / 1ps

module angle_speed_pressure_follower_core_tb;
	import asp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RUN_PHASES = 8;
	localparam int RUN_ITEMS = 216;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	sample_t sample_in;
	logic result_valid;
	logic result_ready;
	result_t result_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	angle_speed_pressure_follower_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow registers and envelope state
	logic                  cfg_enabled = 1'b0;
	logic [SCALE_W-1:0]    cfg_full_scale = FULL_SCALE_RST;
	logic [SCALE_W-1:0]    cfg_deadband = DEADBAND_RST;
	logic [WEIGHT_W-1:0]   cfg_attack = ATTACK_RST;
	logic [WEIGHT_W-1:0]   cfg_release = RELEASE_RST;
	logic [ANGLE_W-1:0]    last_angle = '0;
	logic                  have_angle = 1'b0;
	logic [PRESSURE_W-1:0] env_pressure = '0;
	logic [SPEED_W-1:0]    env_speed = '0;

	sample_t pending_samples[$];
	result_t envelope_due[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	bit sample_taken = 1'b0;
	int walk_angle = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_ignored = 0;
	int n_restart = 0;
	int n_zero_time = 0;
	int n_blended = 0;
	int n_saturated = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Envelope predictor: returns the result for one sample and advances state
	function automatic result_t next_envelope(input sample_t s);
		result_t r;
		logic [ANGLE_W-1:0] delta;
		logic [63:0] rate;
		logic [63:0] scaled;
		logic [63:0] mix;
		logic [SCALE_W-1:0] fs;
		logic [PRESSURE_W-1:0] target;
		logic [WEIGHT_W-1:0] w;
		r.updated = 1'b0;
		if (!cfg_enabled) begin
			n_ignored++;
		end else if (s.restart || !have_angle) begin
			last_angle = s.angle;
			have_angle = 1'b1;
			env_pressure = '0;
			env_speed = '0;
			r.updated = 1'b1;
			n_restart++;
		end else if (s.elapsed_ms == '0) begin
			last_angle = s.angle;
			n_zero_time++;
		end else begin
			delta = (s.angle >= last_angle) ? s.angle - last_angle : last_angle - s.angle;
			rate = (64'(delta) * 64'd1000) / 64'(s.elapsed_ms);
			if (rate < 64'(cfg_deadband))
				rate = '0;
			env_speed = rate[SPEED_W-1:0];
			fs = (cfg_full_scale == '0) ? SCALE_W'(1) : cfg_full_scale;
			scaled = (rate << 16) / 64'(fs);
			if (scaled > 64'(PRESSURE_MAX)) begin
				target = PRESSURE_MAX;
				n_saturated++;
			end else begin
				target = scaled[PRESSURE_W-1:0];
			end
			// attack when rising or level, release when falling
			w = (target >= env_pressure) ? cfg_attack : cfg_release;
			if (w > WEIGHT_ONE)
				w = WEIGHT_ONE;
			mix = (64'(w) * 64'(target) + 64'(WEIGHT_ONE - w) * 64'(env_pressure) + 64'd128) >> 8;
			env_pressure = (mix > 64'(PRESSURE_MAX)) ? PRESSURE_MAX : mix[PRESSURE_W-1:0];
			last_angle = s.angle;
			r.updated = 1'b1;
			n_blended++;
		end
		r.pressure = env_pressure;
		r.speed = env_speed;
		return r;
	endfunction

	// Sample driver: presents queued samples at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_taken) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_in <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
		sample_taken = 1'b0;
	end

	// Result receiver: random stalls plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predict on each accepted sample, check each accepted result
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				envelope_due.push_back(next_envelope(sample_in));
				sample_taken = 1'b1;
				n_samples++;
			end
			if (result_valid && result_ready) begin
				n_results++;
				if (envelope_due.size() == 0) begin
					$error("result with none pending: pressure %0d speed %0d updated %0d",
						result_out.pressure, result_out.speed, result_out.updated);
					mismatch_count++;
				end else begin
					want = envelope_due.pop_front();
					if (result_out.pressure !== want.pressure) begin
						$error("pressure: expected %0d, got %0d", want.pressure, result_out.pressure);
						mismatch_count++;
					end
					if (result_out.speed !== want.speed) begin
						$error("speed: expected %0d, got %0d", want.speed, result_out.speed);
						mismatch_count++;
					end
					if (result_out.updated !== want.updated) begin
						$error("updated: expected %0d, got %0d", want.updated, result_out.updated);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				envelope_due.size());
			$display("angle_speed_pressure_follower_core verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ENABLE:     cfg_enabled = data[0];
			CFG_FULL_SCALE: cfg_full_scale = data[SCALE_W-1:0];
			CFG_DEADBAND:   cfg_deadband = data[SCALE_W-1:0];
			CFG_ATTACK:     cfg_attack = data[WEIGHT_W-1:0];
			CFG_RELEASE:    cfg_release = data[WEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_sample(input int ang, input int ms, input bit rst);
		sample_t s;
		s.angle = ANGLE_W'(ang);
		s.elapsed_ms = ELAPSED_W'(ms);
		s.restart = rst;
		pending_samples.push_back(s);
	endtask

	// Wait until every sample is taken and every result has come back
	task automatic drain_follower();
		while (pending_samples.size() != 0 || sample_valid || envelope_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly smooth hinge motion, with restarts, zero-time and noise mixed in
	task automatic queue_random_samples(input int count);
		int pick;
		int step;
		int ang;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				walk_angle = $urandom_range(36000);
				add_sample(walk_angle, $urandom_range(65535), 1'b1);
			end else if (pick < 8) begin
				walk_angle = $urandom_range(36000);
				add_sample(walk_angle, 0, 1'b0);
			end else if (pick < 16) begin
				ang = $urandom_range(65535);
				add_sample(ang, $urandom_range(65535), $urandom_range(1) == 0 ? 1'b0 : 1'b1);
				walk_angle = (ang > 36000) ? 36000 : ang;
			end else begin
				step = ($urandom_range(2) == 0) ? $urandom_range(3000) : $urandom_range(200);
				if ($urandom_range(3) == 0)
					step = 0;
				ang = ($urandom_range(1) == 0) ? walk_angle + step : walk_angle - step;
				if (ang < 0)
					ang = 0;
				if (ang > 36000)
					ang = 36000;
				walk_angle = ang;
				add_sample(ang, $urandom_range(1, 40), 1'b0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_in = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Out of reset the sensor is off: samples, restart included, are ignored
		add_sample(1000, 20, 1'b0);
		add_sample(500, 10, 1'b1);
		add_sample(0, 0, 1'b0);
		drain_follower();

		// Reset register values: first sample, zero time, deadband edge, no-wrap
		write_reg(CFG_ENABLE, CFG_DATA_W'(1));
		add_sample(18000, 10, 1'b0);
		add_sample(18100, 0, 1'b0);
		add_sample(18200, 10, 1'b0);
		add_sample(18200, 10, 1'b0);
		add_sample(18209, 1000, 1'b0);
		add_sample(18309, 1000, 1'b0);
		add_sample(0, 1, 1'b0);
		add_sample(36000, 65535, 1'b0);
		add_sample(65535, 1, 1'b0);
		add_sample(0, 1, 1'b0);
		add_sample(0, 65535, 1'b1);
		add_sample(100, 65535, 1'b0);
		drain_follower();

		// Zero full scale acts as one; full attack, no release
		write_reg(CFG_FULL_SCALE, '0);
		write_reg(CFG_DEADBAND, '0);
		write_reg(CFG_ATTACK, CFG_DATA_W'(WEIGHT_ONE));
		write_reg(CFG_RELEASE, '0);
		add_sample(5000, 7, 1'b0);
		add_sample(5000, 7, 1'b0);
		add_sample(5001, 65535, 1'b0);
		drain_follower();

		// Register maxima: weights saturate, huge deadband
		write_reg(CFG_FULL_SCALE, {SCALE_W{1'b1}});
		write_reg(CFG_DEADBAND, {SCALE_W{1'b1}});
		write_reg(CFG_ATTACK, CFG_DATA_W'({WEIGHT_W{1'b1}}));
		write_reg(CFG_RELEASE, CFG_DATA_W'({WEIGHT_W{1'b1}}));
		add_sample(30000, 1, 1'b0);
		add_sample(30000, 3, 1'b0);
		add_sample(30500, 1, 1'b0);
		drain_follower();

		// Only bit 0 enables; the rest of the word is ignored
		write_reg(CFG_ENABLE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
		add_sample(12345, 9, 1'b1);
		drain_follower();
		write_reg(CFG_ENABLE, CFG_DATA_W'(1));

		// Random phases, each with its own settings and idling pattern
		for (int p = 0; p < RUN_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 52; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 52; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			case ($urandom_range(5))
				0: write_reg(CFG_FULL_SCALE, CFG_DATA_W'(1));
				1: write_reg(CFG_FULL_SCALE, {SCALE_W{1'b1}});
				default: write_reg(CFG_FULL_SCALE, CFG_DATA_W'($urandom_range(500, 60000)));
			endcase
			case ($urandom_range(7))
				0: write_reg(CFG_DEADBAND, '0);
				1: write_reg(CFG_DEADBAND, CFG_DATA_W'(1000000));
				default: write_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(500)));
			endcase
			write_reg(CFG_ATTACK, CFG_DATA_W'($urandom_range(3) == 0 ?
				$urandom_range(511) : $urandom_range(256)));
			write_reg(CFG_RELEASE, CFG_DATA_W'($urandom_range(3) == 0 ?
				$urandom_range(511) : $urandom_range(256)));
			// long receiver hold-off while the sender keeps offering
			if (p == 0)
				hold_req = 1'b1;
			queue_random_samples(RUN_ITEMS);
			drain_follower();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (60) @(posedge clk);
		$display("covered %0d samples and %0d results: %0d blends (%0d saturated targets),",
			n_samples, n_results, n_blended, n_saturated);
		$display("%0d restarts, %0d zero-time samples, %0d ignored while disabled",
			n_restart, n_zero_time, n_ignored);
		if (mismatch_count == 0 && envelope_due.size() == 0) begin
			$display("angle_speed_pressure_follower_core verification clean");
		end else begin
			$display("angle_speed_pressure_follower_core verification failed");
		end
		$finish;
	end

endmodule
